// ----- hdl/i2crts_pkg.sv -----
// shared types, codes and bcd helpers for the rtc time transfer sequencer
package i2crts_pkg;

    localparam int TIME_BYTES = 3;
    localparam int CNT_W      = $clog2(TIME_BYTES + 1);
    localparam int IDX_W      = (TIME_BYTES > 1) ? $clog2(TIME_BYTES) : 1;

    localparam int CMD_W    = 2;
    localparam int ACTION_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [7:0] STATUS_MASK    = 8'hFC;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    localparam logic [7:0] DEV_ADDR_WR = 8'hD0;
    localparam logic [7:0] DEV_ADDR_RD = 8'hD1;
    localparam logic [7:0] REG_PTR     = 8'h00;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EVENT = 2'd2
    } t_cmd;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_SEND    = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_STOP    = 3'd4,
        ACT_ACK     = 3'd5,
        ACT_NACK    = 3'd6
    } t_action;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [6:0]       set_seconds;
        logic [6:0]       set_minutes;
        logic [6:0]       set_hours;
        logic [7:0]       bus_status;
        logic [7:0]       rx_byte;
    } t_item;

    typedef struct packed {
        t_action    bus_action;
        logic [7:0] tx_byte;
        logic       busy_res;
        logic       rejected;
        logic       time_valid;
        logic [7:0] seconds_out;
        logic [7:0] minutes_out;
        logic [7:0] hours_out;
    } t_result;

    // divide by ten as multiply by 205 and shift, exact below 1029
    function automatic logic [7:0] to_bcd(input logic [6:0] d);
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        p = 15'(d) * 15'd205;
        t = p[14:11];
        o = d - 7'(7'(t) * 7'd10);
        return {t, o[3:0]};
    endfunction

    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        return 8'({4'b0, v[7:4]} * 8'd10) + {4'b0, v[3:0]};
    endfunction

endpackage

// ----- hdl/i2crts_seq.sv -----
// transfer state, byte stores and next bus action for one word
module i2crts_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  i2crts_pkg::t_item   i_item,
    output i2crts_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } t_mode;

    t_mode                        r_mode, n_mode;
    logic [i2crts_pkg::CNT_W-1:0] r_sent, n_sent;
    logic [i2crts_pkg::CNT_W-1:0] r_recv, n_recv;
    logic [7:0]                   r_send_store [i2crts_pkg::TIME_BYTES];
    logic [7:0]                   r_recv_store [i2crts_pkg::TIME_BYTES];
    logic                         load_send;
    logic                         store_rx;
    logic [7:0]                   status;
    logic [7:0]                   time_vals [3];

    assign status = i_item.bus_status & i2crts_pkg::STATUS_MASK;

    // decoded time bytes, zero for slots past the store depth
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            time_vals[i] = 8'd0;
            if (i < i2crts_pkg::TIME_BYTES) begin
                time_vals[i] = i2crts_pkg::from_bcd(r_recv_store[i]);
            end
        end
    end

    always_comb begin
        n_mode    = r_mode;
        n_sent    = r_sent;
        n_recv    = r_recv;
        load_send = 1'b0;
        store_rx  = 1'b0;
        o_res     = '0;
        o_res.bus_action = i2crts_pkg::ACT_NONE;
        case (i2crts_pkg::t_cmd'(i_item.command))
            i2crts_pkg::CMD_WRITE, i2crts_pkg::CMD_READ: begin
                if (r_mode != MODE_IDLE) begin
                    o_res.rejected = 1'b1;
                end else begin
                    o_res.bus_action = i2crts_pkg::ACT_START;
                    if (i_item.command == i2crts_pkg::CMD_WRITE) begin
                        n_mode    = MODE_WRITE;
                        load_send = 1'b1;
                    end else begin
                        n_mode = MODE_READ;
                    end
                end
            end
            i2crts_pkg::CMD_EVENT: begin
                case (status)
                    i2crts_pkg::ST_START: begin
                        if (r_mode == MODE_WRITE || r_mode == MODE_READ) begin
                            o_res.bus_action = i2crts_pkg::ACT_SEND;
                            o_res.tx_byte    = i2crts_pkg::DEV_ADDR_WR;
                        end
                    end
                    i2crts_pkg::ST_RESTART: begin
                        if (r_mode == MODE_READ) begin
                            o_res.bus_action = i2crts_pkg::ACT_SEND;
                            o_res.tx_byte    = i2crts_pkg::DEV_ADDR_RD;
                        end
                    end
                    i2crts_pkg::ST_ADDR_W_ACK: begin
                        o_res.bus_action = i2crts_pkg::ACT_SEND;
                        o_res.tx_byte    = i2crts_pkg::REG_PTR;
                    end
                    i2crts_pkg::ST_DATA_W_ACK: begin
                        if (r_mode == MODE_WRITE) begin
                            if (r_sent < i2crts_pkg::CNT_W'(i2crts_pkg::TIME_BYTES)) begin
                                o_res.bus_action = i2crts_pkg::ACT_SEND;
                                o_res.tx_byte    =
                                    r_send_store[r_sent[i2crts_pkg::IDX_W-1:0]];
                                n_sent = r_sent + i2crts_pkg::CNT_W'(1);
                            end else begin
                                o_res.bus_action = i2crts_pkg::ACT_STOP;
                                n_mode = MODE_IDLE;
                                n_sent = '0;
                            end
                        end else if (r_mode == MODE_READ) begin
                            o_res.bus_action = i2crts_pkg::ACT_RESTART;
                        end
                    end
                    i2crts_pkg::ST_ADDR_R_ACK: begin
                        o_res.bus_action = i2crts_pkg::ACT_ACK;
                    end
                    i2crts_pkg::ST_DATA_R_ACK: begin
                        if (r_recv < i2crts_pkg::CNT_W'(i2crts_pkg::TIME_BYTES)) begin
                            store_rx = 1'b1;
                            n_recv   = r_recv + i2crts_pkg::CNT_W'(1);
                            o_res.bus_action = i2crts_pkg::ACT_ACK;
                        end else begin
                            // extra byte past the kept ones ends the read
                            if (r_mode == MODE_READ) begin
                                o_res.time_valid  = 1'b1;
                                o_res.seconds_out = time_vals[0];
                                o_res.minutes_out = time_vals[1];
                                o_res.hours_out   = time_vals[2];
                            end
                            n_mode = MODE_IDLE;
                            n_recv = '0;
                            o_res.bus_action = i2crts_pkg::ACT_NACK;
                        end
                    end
                    i2crts_pkg::ST_DATA_R_NACK: begin
                        o_res.bus_action = i2crts_pkg::ACT_STOP;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
        o_res.busy_res = (n_mode != MODE_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_sent <= '0;
            r_recv <= '0;
        end else if (i_acc) begin
            r_mode <= n_mode;
            r_sent <= n_sent;
            r_recv <= n_recv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && load_send) begin
            for (int i = 0; i < 3; i++) begin
                if (i < i2crts_pkg::TIME_BYTES) begin
                    case (i)
                        0:       r_send_store[i] <= i2crts_pkg::to_bcd(i_item.set_seconds);
                        1:       r_send_store[i] <= i2crts_pkg::to_bcd(i_item.set_minutes);
                        default: r_send_store[i] <= i2crts_pkg::to_bcd(i_item.set_hours);
                    endcase
                end
            end
        end
        if (i_acc && store_rx) begin
            r_recv_store[r_recv[i2crts_pkg::IDX_W-1:0]] <= i_item.rx_byte;
        end
    end

endmodule

// ----- hdl/i2c_rtc_time_transfer_sequencer_core.sv -----
// top level of the rtc time transfer sequencer with stream handshake
//
//  side    group               content
//  in      i_s_* / o_s_tready  command (tuser), time values, bus status, rx byte
//  out     o_m_* / i_m_tready  bus action, tx byte, flags, decoded time
//
// one word per cycle while the output is not stalled; each accepted word gives its result
// in the next cycle from the output register, set by the single state update per word
// a new word is taken while the output register is empty or being drained
// synchronous active-low reset returns to idle with counters cleared
module i2c_rtc_time_transfer_sequencer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // set_seconds[6:0], set_minutes[13:7], set_hours[20:14], bus_status[28:21],
    // rx_byte[36:29], zero pad [39:37]
    input  logic [i2crts_pkg::S_DATA_W-1:0]   i_s_tdata,
    // command[1:0]
    input  logic [i2crts_pkg::CMD_W-1:0]      i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // bus_action[2:0], tx_byte[10:3], busy_res[11], rejected[12], time_valid[13],
    // seconds_out[21:14], minutes_out[29:22], hours_out[37:30], zero pad [39:38]
    output logic [i2crts_pkg::M_DATA_W-1:0]   o_m_tdata
);

    logic                            acc;
    i2crts_pkg::t_item               item;
    i2crts_pkg::t_result             res;
    logic                            r_m_valid;
    logic [i2crts_pkg::M_DATA_W-1:0] r_m_data;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign acc        = i_s_tvalid && o_s_tready;

    assign item.command     = i_s_tuser;
    assign item.set_seconds = i_s_tdata[6:0];
    assign item.set_minutes = i_s_tdata[13:7];
    assign item.set_hours   = i_s_tdata[20:14];
    assign item.bus_status  = i_s_tdata[28:21];
    assign item.rx_byte     = i_s_tdata[36:29];

    i2crts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_item  (item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_m_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_m_data <= {2'b0, res.hours_out, res.minutes_out, res.seconds_out,
                         res.time_valid, res.rejected, res.busy_res, res.tx_byte,
                         res.bus_action};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- hdl/i2crts_chk.sv -----
// port-level checks for the rtc time transfer sequencer
module i2crts_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [i2crts_pkg::M_DATA_W-1:0] o_m_tdata
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted word gave no result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // a finished read answers nack and leaves the block idle
    a_done_nack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[13] |->
            o_m_tdata[2:0] == i2crts_pkg::ACT_NACK && !o_m_tdata[11])
        else $error("time valid without nack and idle");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[12] |->
            o_m_tdata[2:0] == i2crts_pkg::ACT_NONE && o_m_tdata[11])
        else $error("rejected start did something");

endmodule

bind i2c_rtc_time_transfer_sequencer_core i2crts_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ----- sim/tb.sv -----
// self-checking testbench for the rtc time transfer sequencer core
module tb;

    localparam logic [i2crts_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int WORD_TARGET   = 1500;
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOW_LIMIT    = 10;

    typedef enum logic [1:0] {
        XFER_IDLE  = 2'd0,
        XFER_WRITE = 2'd1,
        XFER_READ  = 2'd2
    } t_xfer;

    // tracks the sequencer state and queues the result each accepted word must give
    class sequencer_board;
        t_xfer                 mode;
        int                    sent_cnt;
        int                    recv_cnt;
        logic [7:0]            tx_bytes [i2crts_pkg::TIME_BYTES];
        logic [7:0]            rx_bytes [i2crts_pkg::TIME_BYTES];
        i2crts_pkg::t_result   due_results[$];
        int                    errors;
        int                    checked;

        function new();
            mode     = XFER_IDLE;
            sent_cnt = 0;
            recv_cnt = 0;
            errors   = 0;
            checked  = 0;
        endfunction

        function logic [7:0] dec_to_bcd(logic [6:0] d);
            int v;
            v = d;
            return 8'((v / 10) * 16 + v % 10);
        endfunction

        function logic [7:0] bcd_to_dec(logic [7:0] b);
            int v;
            v = int'(b[7:4]) * 10 + int'(b[3:0]);
            return v[7:0];
        endfunction

        function void take_word(i2crts_pkg::t_item w);
            i2crts_pkg::t_result r;
            logic [7:0]          st;
            r = '0;
            r.bus_action = i2crts_pkg::ACT_NONE;
            st = w.bus_status & i2crts_pkg::STATUS_MASK;
            if (w.command == i2crts_pkg::CMD_WRITE || w.command == i2crts_pkg::CMD_READ) begin
                if (mode != XFER_IDLE) begin
                    r.rejected = 1'b1;
                end else if (w.command == i2crts_pkg::CMD_WRITE) begin
                    tx_bytes[0] = dec_to_bcd(w.set_seconds);
                    tx_bytes[1] = dec_to_bcd(w.set_minutes);
                    tx_bytes[2] = dec_to_bcd(w.set_hours);
                    mode = XFER_WRITE;
                    r.bus_action = i2crts_pkg::ACT_START;
                end else begin
                    mode = XFER_READ;
                    r.bus_action = i2crts_pkg::ACT_START;
                end
            end else if (w.command == i2crts_pkg::CMD_EVENT) begin
                case (st)
                    i2crts_pkg::ST_START: begin
                        if (mode != XFER_IDLE) begin
                            r.bus_action = i2crts_pkg::ACT_SEND;
                            r.tx_byte = i2crts_pkg::DEV_ADDR_WR;
                        end
                    end
                    i2crts_pkg::ST_RESTART: begin
                        if (mode == XFER_READ) begin
                            r.bus_action = i2crts_pkg::ACT_SEND;
                            r.tx_byte = i2crts_pkg::DEV_ADDR_RD;
                        end
                    end
                    i2crts_pkg::ST_ADDR_W_ACK: begin
                        r.bus_action = i2crts_pkg::ACT_SEND;
                        r.tx_byte = i2crts_pkg::REG_PTR;
                    end
                    i2crts_pkg::ST_DATA_W_ACK: begin
                        if (mode == XFER_WRITE) begin
                            if (sent_cnt < i2crts_pkg::TIME_BYTES) begin
                                r.bus_action = i2crts_pkg::ACT_SEND;
                                r.tx_byte = tx_bytes[sent_cnt];
                                sent_cnt++;
                            end else begin
                                r.bus_action = i2crts_pkg::ACT_STOP;
                                mode = XFER_IDLE;
                                sent_cnt = 0;
                            end
                        end else if (mode == XFER_READ) begin
                            r.bus_action = i2crts_pkg::ACT_RESTART;
                        end
                    end
                    i2crts_pkg::ST_ADDR_R_ACK: r.bus_action = i2crts_pkg::ACT_ACK;
                    i2crts_pkg::ST_DATA_R_ACK: begin
                        if (recv_cnt < i2crts_pkg::TIME_BYTES) begin
                            rx_bytes[recv_cnt] = w.rx_byte;
                            recv_cnt++;
                            r.bus_action = i2crts_pkg::ACT_ACK;
                        end else begin
                            // the extra byte closes the read and is dropped
                            if (mode == XFER_READ) begin
                                r.time_valid  = 1'b1;
                                r.seconds_out = bcd_to_dec(rx_bytes[0]);
                                r.minutes_out = bcd_to_dec(rx_bytes[1]);
                                r.hours_out   = bcd_to_dec(rx_bytes[2]);
                            end
                            mode = XFER_IDLE;
                            recv_cnt = 0;
                            r.bus_action = i2crts_pkg::ACT_NACK;
                        end
                    end
                    i2crts_pkg::ST_DATA_R_NACK: r.bus_action = i2crts_pkg::ACT_STOP;
                    default: ;
                endcase
            end
            r.busy_res = (mode != XFER_IDLE);
            due_results.push_back(r);
        endfunction

        function void match_word(i2crts_pkg::t_result got);
            i2crts_pkg::t_result want;
            checked++;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected result word %0d: act=%0d tx=%02h", checked,
                             got.bus_action, got.tx_byte);
                return;
            end
            want = due_results.pop_front();
            if (got.bus_action !== want.bus_action || got.tx_byte !== want.tx_byte ||
                got.busy_res !== want.busy_res || got.rejected !== want.rejected ||
                got.time_valid !== want.time_valid || got.seconds_out !== want.seconds_out ||
                got.minutes_out !== want.minutes_out || got.hours_out !== want.hours_out) begin
                errors++;
                if (errors <= SHOW_LIMIT) begin
                    $display("result word %0d: expected act=%0d tx=%02h busy=%b rej=%b tv=%b %0d:%0d:%0d",
                             checked, want.bus_action, want.tx_byte, want.busy_res,
                             want.rejected, want.time_valid, want.hours_out,
                             want.minutes_out, want.seconds_out);
                    $display("    got      act=%0d tx=%02h busy=%b rej=%b tv=%b %0d:%0d:%0d",
                             got.bus_action, got.tx_byte, got.busy_res, got.rejected,
                             got.time_valid, got.hours_out, got.minutes_out, got.seconds_out);
                end
            end
        endfunction

        function void close_out();
            if (due_results.size() != 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("%0d result words never arrived", due_results.size());
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [i2crts_pkg::S_DATA_W-1:0] i_s_tdata = '0;
    logic [i2crts_pkg::CMD_W-1:0]    i_s_tuser = i2crts_pkg::CMD_EVENT;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [i2crts_pkg::M_DATA_W-1:0] o_m_tdata;

    sequencer_board board = new();
    int   words_sent = 0;
    bit   no_gaps = 1'b0;
    i2crts_pkg::t_item plan[$];
    logic [7:0] known_codes [7] = '{i2crts_pkg::ST_START, i2crts_pkg::ST_RESTART,
                                    i2crts_pkg::ST_ADDR_W_ACK, i2crts_pkg::ST_DATA_W_ACK,
                                    i2crts_pkg::ST_ADDR_R_ACK, i2crts_pkg::ST_DATA_R_ACK,
                                    i2crts_pkg::ST_DATA_R_NACK};

    i2c_rtc_time_transfer_sequencer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic i2crts_pkg::t_item make_word(logic [i2crts_pkg::CMD_W-1:0] cmd,
                                                    logic [7:0] st, logic [7:0] rx,
                                                    logic [6:0] s, logic [6:0] m,
                                                    logic [6:0] h);
        i2crts_pkg::t_item w;
        w.command     = cmd;
        w.bus_status  = st;
        w.rx_byte     = rx;
        w.set_seconds = s;
        w.set_minutes = m;
        w.set_hours   = h;
        return w;
    endfunction

    function automatic logic [6:0] rand_time();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, 99));
    endfunction

    // bus event with random masked bits and random unused fields
    function automatic i2crts_pkg::t_item bus_word(logic [7:0] code);
        return make_word(i2crts_pkg::CMD_EVENT, code | 8'($urandom_range(0, 3)), 8'($urandom),
                         7'($urandom), 7'($urandom), 7'($urandom));
    endfunction

    function automatic i2crts_pkg::t_item noise_word();
        logic [7:0] st;
        if ($urandom_range(0, 1) == 0)
            st = 8'($urandom);
        else
            st = known_codes[$urandom_range(0, 6)] | 8'($urandom_range(0, 3));
        return make_word(i2crts_pkg::CMD_W'($urandom_range(0, 3)), st, 8'($urandom),
                         rand_time(), rand_time(), rand_time());
    endfunction

    function automatic i2crts_pkg::t_result unpack_result(logic [i2crts_pkg::M_DATA_W-1:0] d);
        i2crts_pkg::t_result r;
        r.bus_action  = i2crts_pkg::t_action'(d[2:0]);
        r.tx_byte     = d[10:3];
        r.busy_res    = d[11];
        r.rejected    = d[12];
        r.time_valid  = d[13];
        r.seconds_out = d[21:14];
        r.minutes_out = d[29:22];
        r.hours_out   = d[37:30];
        return r;
    endfunction

    task automatic put_word(i2crts_pkg::t_item w);
        if (!no_gaps && $urandom_range(0, 99) < 6) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= w.command;
        i_s_tdata  <= {3'b0, w.rx_byte, w.bus_status, w.set_hours, w.set_minutes,
                       w.set_seconds};
        do @(posedge i_clk); while (!o_s_tready);
        board.take_word(w);
        words_sent++;
    endtask

    // sends the planned words, now and then slipping in noise or cutting the plan short
    task automatic send_plan();
        int k;
        for (k = 0; k < plan.size(); k++) begin
            if ($urandom_range(0, 99) < 6)
                put_word(noise_word());
            if ($urandom_range(0, 99) < 2)
                break;
            put_word(plan[k]);
        end
        plan.delete();
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (board.due_results.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.match_word(unpack_result(o_m_tdata));
        i_m_tready <= no_gaps || ($urandom_range(0, 99) >= 6);
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stalled = 0;
            else
                stalled++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int  pick;
        int  k;
        bit  paused;
        paused = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle corner cases
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_START, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_RESTART, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_W_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_ADDR_W_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(CMD_SPARE, 8'hFF, 8'hFF, 7'd127, 7'd127, 7'd127));
        put_word(make_word(i2crts_pkg::CMD_EVENT, 8'hFF, 8'hFF, 7'd0, 7'd0, 7'd0));
        // full write with extreme values, then a refused start
        put_word(make_word(i2crts_pkg::CMD_WRITE, 8'h00, 8'h00, 7'd0, 7'd127, 7'd99));
        put_word(make_word(i2crts_pkg::CMD_WRITE, 8'h00, 8'h00, 7'd59, 7'd59, 7'd23));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_START, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_ADDR_W_ACK | 8'h03, 8'h00,
                           7'd0, 7'd0, 7'd0));
        for (k = 0; k < 4; k++)
            put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_W_ACK, 8'h00,
                               7'd0, 7'd0, 7'd0));
        // full read with all-ones and zero bytes
        put_word(make_word(i2crts_pkg::CMD_READ, 8'h00, 8'h00, 7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_START, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_ADDR_W_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_W_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_RESTART, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_ADDR_R_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_R_ACK, 8'hFF,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_R_ACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_R_ACK, 8'h59,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_R_ACK, 8'hAA,
                           7'd0, 7'd0, 7'd0));
        put_word(make_word(i2crts_pkg::CMD_EVENT, i2crts_pkg::ST_DATA_R_NACK, 8'h00,
                           7'd0, 7'd0, 7'd0));
        wait_drained();

        while (words_sent < WORD_TARGET) begin
            no_gaps = (words_sent >= 900 && words_sent < 1200);
            if (!paused && words_sent >= 700) begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                plan.push_back(make_word(i2crts_pkg::CMD_WRITE, 8'($urandom), 8'($urandom),
                                         rand_time(), rand_time(), rand_time()));
                plan.push_back(bus_word(i2crts_pkg::ST_START));
                plan.push_back(bus_word(i2crts_pkg::ST_ADDR_W_ACK));
                for (k = 0; k < i2crts_pkg::TIME_BYTES + 1; k++)
                    plan.push_back(bus_word(i2crts_pkg::ST_DATA_W_ACK));
            end else if (pick < 8) begin
                plan.push_back(make_word(i2crts_pkg::CMD_READ, 8'($urandom), 8'($urandom),
                                         rand_time(), rand_time(), rand_time()));
                plan.push_back(bus_word(i2crts_pkg::ST_START));
                plan.push_back(bus_word(i2crts_pkg::ST_ADDR_W_ACK));
                plan.push_back(bus_word(i2crts_pkg::ST_DATA_W_ACK));
                plan.push_back(bus_word(i2crts_pkg::ST_RESTART));
                plan.push_back(bus_word(i2crts_pkg::ST_ADDR_R_ACK));
                for (k = 0; k < i2crts_pkg::TIME_BYTES + 1; k++)
                    plan.push_back(bus_word(i2crts_pkg::ST_DATA_R_ACK));
                plan.push_back(bus_word(i2crts_pkg::ST_DATA_R_NACK));
            end else if (pick == 8) begin
                // receive events outside a read
                for (k = 0; k < i2crts_pkg::TIME_BYTES + 1; k++)
                    plan.push_back(bus_word(i2crts_pkg::ST_DATA_R_ACK));
            end else begin
                for (k = 0; k < 3; k++)
                    plan.push_back(noise_word());
            end
            send_plan();
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (10) @(posedge i_clk);
        board.close_out();
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
